/* hw/rtl/bfpa_pkg.sv */
// ----------------------------------------------------------------------------
// bfpa_pkg
// Types and codes shared by the best-fit partition allocator: the command and
// status codes and the packed item types of the input and result channels.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned AMOUNT_W = 32;
    localparam int unsigned SEL_W    = 4;
    localparam int unsigned STATUS_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEALLOC = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    // Input item.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [AMOUNT_W-1:0] amount;
        logic [SEL_W-1:0]    part_sel;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEL_W-1:0]    part_index;
        logic [AMOUNT_W-1:0] free_after;
    } out_t;

endpackage

/* hw/rtl/best_fit_partition_allocator.sv */
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Keeps a table of partition free sizes in a synchronous memory. Add appends a
// partition, allocate scans the used entries for the best fit and takes the
// request off it, deallocate adds a size back with saturation.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                      | Direction | Item
//  ---------+----------------------------+-----------+---------------------------
//  s_       | s_valid, s_ready, s_data   | in        | cmd, amount, part_sel
//  m_       | m_valid, m_ready, m_data   | out       | status, part_index, free_after
//
// One item is in work at a time. Add, the unused command and the errors found
// without a table read go straight to the result state; deallocate reads the
// entry and then writes the saturated sum, and allocate on a non-empty table
// scans the used entries, reading one table entry per cycle through the
// single read port of the table memory.
// Reset clears the partition count and the control state; the table itself
// holds no reset value, and no entry is read before an add has written it.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits for that register before its own result is shown.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator #(
    parameter int unsigned PARTITIONS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bfpa_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bfpa_pkg::out_t   m_data
);

    localparam int unsigned IW = $clog2(PARTITIONS);
    localparam int unsigned CW = $clog2(PARTITIONS + 1);
    localparam int unsigned XW = CW + bfpa_pkg::SEL_W;
    localparam int unsigned AW = bfpa_pkg::AMOUNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DRD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_AWR  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Control and working registers.
    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         amt_reg, amt_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic [AW-1:0]         best_val_reg, best_val_next;
    bfpa_pkg::out_t        res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    bfpa_pkg::out_t        m_data_reg, m_data_next;

    // Table memory and its port signals.
    logic [AW-1:0]         mem [PARTITIONS];
    logic [AW-1:0]         rdata_reg;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_wdata;
    logic                  mem_re;
    logic [IW-1:0]         mem_raddr;

    // Helper values.
    logic                  s_accept;
    logic                  out_free;
    logic                  hit;
    logic                  last;
    logic [AW:0]           sum;
    logic [AW-1:0]         sat_sum;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // A scanned entry fits and beats the best so far; ties keep the lower index.
    assign hit  = (rdata_reg >= amt_reg) && (!found_reg || (rdata_reg < best_val_reg));
    assign last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // Saturating add for deallocate.
    assign sum     = {1'b0, rdata_reg} + {1'b0, amt_reg};
    assign sat_sum = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        amt_next      = amt_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = amt_reg;
        mem_re        = 1'b0;
        mem_raddr     = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    amt_next   = s_data.amount;
                    found_next = 1'b0;
                    state_next = S_DONE;
                    res_next   = '{status: bfpa_pkg::ST_BADIDX, part_index: '0,
                                   free_after: '0};
                    unique case (s_data.cmd)
                        bfpa_pkg::CMD_ADD: begin
                            if (count_reg >= CW'(PARTITIONS)) begin
                                res_next.status = bfpa_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = IW'(count_reg);
                                mem_wdata  = s_data.amount;
                                count_next = count_reg + CW'(1);
                                res_next   = '{status: bfpa_pkg::ST_OK,
                                               part_index: bfpa_pkg::SEL_W'(count_reg),
                                               free_after: s_data.amount};
                            end
                        end
                        bfpa_pkg::CMD_ALLOC: begin
                            if (count_reg == '0) begin
                                res_next.status = bfpa_pkg::ST_NOFIT;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        bfpa_pkg::CMD_DEALLOC: begin
                            if (XW'(s_data.part_sel) < XW'(count_reg)) begin
                                mem_re     = 1'b1;
                                mem_raddr  = IW'(s_data.part_sel);
                                idx_next   = IW'(s_data.part_sel);
                                state_next = S_DRD;
                            end
                        end
                        default: begin
                            // Unused command: reported as a bad index.
                        end
                    endcase
                end
            end

            S_DRD: begin
                // Read data is back: write the saturated sum.
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = sat_sum;
                res_next   = '{status: bfpa_pkg::ST_OK,
                               part_index: bfpa_pkg::SEL_W'(idx_reg),
                               free_after: sat_sum};
                state_next = S_DONE;
            end

            S_SCAN: begin
                // Compare the entry just read and fetch the next one.
                if (hit) begin
                    found_next    = 1'b1;
                    best_idx_next = idx_reg;
                    best_val_next = rdata_reg;
                end
                if (last) begin
                    state_next = S_AWR;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + IW'(1);
                    idx_next  = idx_reg + IW'(1);
                end
            end

            S_AWR: begin
                // Take the request off the best entry, or report no fit.
                if (found_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = best_idx_reg;
                    mem_wdata = best_val_reg - amt_reg;
                    res_next  = '{status: bfpa_pkg::ST_OK,
                                  part_index: bfpa_pkg::SEL_W'(best_idx_reg),
                                  free_after: best_val_reg - amt_reg};
                end else begin
                    res_next  = '{status: bfpa_pkg::ST_NOFIT, part_index: '0,
                                  free_after: '0};
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Register update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
        end
        amt_reg      <= amt_next;
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

/* tb/tb_best_fit_partition_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_best_fit_partition_allocator
// Self-checking bench for the best-fit partition allocator. A planner copy of
// the allocator state shapes the commands so that allocations hit exact fits,
// near fits and misses, while a second copy predicts every result at the
// moment its command item is accepted. Both channels idle at random, and the
// run includes a long result stall and a full drain in mid-stream.
// ----------------------------------------------------------------------------
module tb_best_fit_partition_allocator;

    localparam int unsigned PARTS       = 16;
    localparam int unsigned CHECK_COPY  = 0;
    localparam int unsigned PLAN_COPY   = 1;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE      = 40;
    localparam int unsigned MAX_CYCLES  = 1000000;
    localparam logic [bfpa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    bfpa_pkg::in_t   s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    bfpa_pkg::out_t  m_data;

    // Commands waiting to be offered, and results owed by the block.
    bfpa_pkg::in_t   cmd_backlog [$];
    bfpa_pkg::out_t  predicted_replies [$];

    // Two copies of the allocator state: one checks, one plans stimulus.
    logic [31:0] free_tbl [2][PARTS];
    logic [4:0]  used_cnt [2];

    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 88;
    int unsigned n_queued      = 0;
    int unsigned n_accepted    = 0;
    int unsigned n_errors      = 0;
    int unsigned hold_asked    = 0;
    int unsigned hold_granted  = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_cnt     = 0;
    logic        in_taken      = 1'b0;

    best_fit_partition_allocator #(
        .PARTITIONS (PARTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Applies one command to the chosen state copy and returns its result.
    function automatic bfpa_pkg::out_t allocator_step(input bfpa_pkg::in_t item,
                                                      input int unsigned cp);
        bfpa_pkg::out_t res;
        int             best;
        int             i;
        logic [32:0]    sum;
        res = '0;
        res.status = bfpa_pkg::ST_BADIDX;
        case (item.cmd)
            bfpa_pkg::CMD_ADD: begin
                if (used_cnt[cp] >= PARTS) begin
                    res.status = bfpa_pkg::ST_FULL;
                end else begin
                    free_tbl[cp][used_cnt[cp][3:0]] = item.amount;
                    res.status     = bfpa_pkg::ST_OK;
                    res.part_index = used_cnt[cp][3:0];
                    res.free_after = item.amount;
                    used_cnt[cp]   = used_cnt[cp] + 1'b1;
                end
            end
            bfpa_pkg::CMD_ALLOC: begin
                best = -1;
                for (i = 0; i < PARTS; i++) begin
                    if (i < used_cnt[cp] && free_tbl[cp][i] >= item.amount &&
                        (best < 0 || free_tbl[cp][i] < free_tbl[cp][best]))
                        best = i;
                end
                if (best < 0) begin
                    res.status = bfpa_pkg::ST_NOFIT;
                end else begin
                    free_tbl[cp][best] = free_tbl[cp][best] - item.amount;
                    res.status     = bfpa_pkg::ST_OK;
                    res.part_index = best[3:0];
                    res.free_after = free_tbl[cp][best];
                end
            end
            bfpa_pkg::CMD_DEALLOC: begin
                if (item.part_sel < used_cnt[cp]) begin
                    sum = {1'b0, free_tbl[cp][item.part_sel]} + {1'b0, item.amount};
                    free_tbl[cp][item.part_sel] = sum[32] ? ALL_ONES : sum[31:0];
                    res.status     = bfpa_pkg::ST_OK;
                    res.part_index = item.part_sel;
                    res.free_after = free_tbl[cp][item.part_sel];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic bfpa_pkg::in_t mk_item(input logic [1:0] c, input logic [31:0] amt,
                                              input logic [3:0] sel);
        bfpa_pkg::in_t it;
        it.cmd      = c;
        it.amount   = amt;
        it.part_sel = sel;
        return it;
    endfunction

    // Random command shaped by the planner state, so that half the allocations
    // land near an existing free size and most deallocations name a real entry.
    function automatic bfpa_pkg::in_t pick_random_item();
        bfpa_pkg::in_t it;
        int unsigned   r;
        int unsigned   k;
        logic [31:0]   base;
        logic [31:0]   nudge;
        logic [31:0]   sel_draw;
        it.cmd      = bfpa_pkg::CMD_ALLOC;
        it.amount   = $urandom;
        sel_draw    = $urandom_range(15);
        it.part_sel = sel_draw[3:0];
        r     = $urandom_range(99);
        k     = (used_cnt[PLAN_COPY] == 0) ? 0 : $urandom_range(used_cnt[PLAN_COPY] - 1);
        base  = free_tbl[PLAN_COPY][k];
        nudge = $urandom_range(4095);
        if (r < 8) begin
            it.cmd = bfpa_pkg::CMD_ADD;
            case ($urandom_range(3))
                0: it.amount = $urandom_range(65535);
                1: it.amount = ALL_ONES;
                2: it.amount = $urandom >> $urandom_range(31);
                default: ;
            endcase
        end else if (r < 12) begin
            it.cmd = CMD_UNUSED;
        end else if (r < 55) begin
            it.cmd = bfpa_pkg::CMD_ALLOC;
            case ($urandom_range(5))
                0: it.amount = base;
                1: it.amount = (base >= nudge) ? base - nudge : base;
                2: it.amount = base + 32'd1;
                3: it.amount = nudge;
                4: it.amount = 32'd0;
                default: ;
            endcase
        end else begin
            it.cmd = bfpa_pkg::CMD_DEALLOC;
            if ($urandom_range(99) < 85)
                it.part_sel = k[3:0];
            case ($urandom_range(4))
                0: it.amount = nudge;
                1: it.amount = ALL_ONES;
                2: it.amount = ~base;
                3: it.amount = 32'd0;
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic issue(input bfpa_pkg::in_t it);
        void'(allocator_step(it, PLAN_COPY));
        cmd_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic issue_random(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
            issue(pick_random_item());
    endtask

    // Waits until every queued command is accepted and every result is in.
    task automatic wait_drained();
        while (n_accepted != n_queued || predicted_replies.size() != 0)
            @(negedge aclk);
    endtask

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Command driver: a new item goes out only once the previous one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= cmd_backlog.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result acceptance, with an occasional long stall on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_granted != hold_asked) begin
            m_ready      <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_granted <= hold_granted + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each result against the oldest prediction, then
    // predicts the result of any command taken at this edge.
    always @(posedge aclk) begin : monitor
        bfpa_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d index %0d free %0h",
                                              m_data.status, m_data.part_index,
                                              m_data.free_after));
                end else begin
                    want = predicted_replies.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_data.status, want.status));
                    if (m_data.part_index !== want.part_index)
                        report_mismatch($sformatf("part_index got %0d want %0d",
                                                  m_data.part_index, want.part_index));
                    if (m_data.free_after !== want.free_after)
                        report_mismatch($sformatf("free_after got %0h want %0h",
                                                  m_data.free_after, want.free_after));
                end
            end
            if (s_valid && s_ready) begin
                predicted_replies.push_back(allocator_step(s_data, CHECK_COPY));
                n_accepted++;
            end
        end
        in_taken <= aresetn && s_valid && s_ready;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("** best_fit_partition_allocator: FAILED **");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        used_cnt[CHECK_COPY] = '0;
        used_cnt[PLAN_COPY]  = '0;
        for (int i = 0; i < PARTS; i++) begin
            free_tbl[CHECK_COPY][i] = '0;
            free_tbl[PLAN_COPY][i]  = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sender idles often, receiver idles most of the time.
        send_idle_pct = 35;
        recv_idle_pct = 88;

        // Empty table: no fit, bad index and the unused command.
        issue(mk_item(bfpa_pkg::CMD_ALLOC,   32'd5,      4'd0));
        issue(mk_item(bfpa_pkg::CMD_DEALLOC, 32'd7,      4'd0));
        issue(mk_item(CMD_UNUSED,            ALL_ONES,   4'd15));
        // Extreme sizes and a tie between two equal entries.
        issue(mk_item(bfpa_pkg::CMD_ADD,     ALL_ONES,   4'd9));
        issue(mk_item(bfpa_pkg::CMD_ADD,     32'd0,      4'd0));
        issue(mk_item(bfpa_pkg::CMD_ADD,     32'd100,    4'd3));
        issue(mk_item(bfpa_pkg::CMD_ADD,     32'd100,    4'd0));
        // Zero request takes the smallest entry and leaves it as it was.
        issue(mk_item(bfpa_pkg::CMD_ALLOC,   32'd0,      4'd0));
        issue(mk_item(bfpa_pkg::CMD_ALLOC,   32'd50,     4'd0));
        issue(mk_item(bfpa_pkg::CMD_ALLOC,   32'd100,    4'd0));
        // A request of the full range fits only the unbounded entry.
        issue(mk_item(bfpa_pkg::CMD_ALLOC,   ALL_ONES,   4'd0));
        issue(mk_item(bfpa_pkg::CMD_ALLOC,   32'd1,      4'd0));
        // Refill to the maximum, then saturate.
        issue(mk_item(bfpa_pkg::CMD_DEALLOC, ALL_ONES,   4'd0));
        issue(mk_item(bfpa_pkg::CMD_DEALLOC, 32'd1,      4'd0));
        issue(mk_item(bfpa_pkg::CMD_DEALLOC, 32'd1,      4'd4));
        issue(mk_item(bfpa_pkg::CMD_DEALLOC, 32'd1,      4'd15));
        issue(mk_item(bfpa_pkg::CMD_ALLOC,   ALL_ONES,   4'd0));
        issue(mk_item(bfpa_pkg::CMD_ALLOC,   32'h8000_0000, 4'd0));
        issue(mk_item(CMD_UNUSED,            32'h5A5A_A5A5, 4'd6));

        issue_random(325);
        wait_drained();
        issue_random(325);
        wait_drained();

        // Receiver idles often, sender idles most of the time.
        send_idle_pct = 88;
        recv_idle_pct = 35;
        issue_random(325);
        wait_drained();
        issue_random(325);
        wait_drained();

        // No idling; a long result stall lets the block back up its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        issue_random(300);
        wait_drained();
        issue_random(300);
        wait_drained();

        repeat (SETTLE) @(negedge aclk);
        if (n_errors == 0)
            $display("** best_fit_partition_allocator: PASSED **");
        else
            $display("** best_fit_partition_allocator: FAILED **");
        $finish;
    end

endmodule
